@@ design/gbat_pkg.sv @@
// ----------------------------------------------------------------------------
// gbat_pkg
// Widths and the block-end table for the growing-block address translator.
// ----------------------------------------------------------------------------
package gbat_pkg;

  localparam int ADDR_W  = 48;  // byte address / offset
  localparam int CS_W    = 21;  // cluster size register
  localparam int IDX_W   = 6;   // block index on the result channel
  localparam int UNIT_W  = 34;  // block end in clusters, up to block 63
  localparam int PROD_W  = UNIT_W + CS_W;
  localparam int BOUND_W = ADDR_W + 1;  // top bit set = beyond any address
  localparam int GRP     = 8;   // lanes per select group

  localparam logic [CS_W-1:0] CS_RESET = CS_W'(4096);

  // End of block idx (sum of sizes 0..idx) in clusters.
  // Sizes 1,1,2,3 then 4,6,8,12,16,... so from block 4 on the end is
  // 14*2^j-3 for even idx and 20*2^j-3 for odd idx, j = (idx-4)/2.
  function automatic logic [UNIT_W-1:0] cum_units(input logic [IDX_W-1:0] idx);
    logic [IDX_W-1:0]  rel;
    logic [IDX_W-2:0]  j;
    logic [UNIT_W-1:0] base;
    logic [UNIT_W-1:0] res;
    rel  = idx - IDX_W'(4);
    j    = rel[IDX_W-1:1];
    base = idx[0] ? UNIT_W'(20) : UNIT_W'(14);
    priority if (idx == IDX_W'(0)) begin
      res = UNIT_W'(1);
    end else if (idx == IDX_W'(1)) begin
      res = UNIT_W'(2);
    end else if (idx == IDX_W'(2)) begin
      res = UNIT_W'(4);
    end else if (idx == IDX_W'(3)) begin
      res = UNIT_W'(7);
    end else begin
      res = (base << j) - UNIT_W'(3);
    end
    return res;
  endfunction

endpackage

@@ design/growing_block_address_translate_top.sv @@
// ----------------------------------------------------------------------------
// growing_block_address_translate_top
// Maps a stream byte address to the growing block that holds it and the
// offset inside that block.
// ----------------------------------------------------------------------------
//
//  channel | ports                                   | direction
//  --------+-----------------------------------------+-----------------------
//  in      | in_valid, in_stall, in_address          | item in, stall out
//  out     | out_valid, out_stall, out_block_index,  | item out, stall in
//          | out_offset_in_block, out_found          |
//  cfg     | cfg_we, cfg_wdata                       | cluster size write
//
//  One item per cycle sustained while in_stall and out_stall stay low; an
//  accepted item passes input reg, compare, group select and output reg.
//  Block end addresses sit in a register table, rebuilt one block per cycle
//  through one 34x21 multiplier; after reset and after every cfg write the
//  rebuild holds in_stall high until the table is complete.
//  out_stall backs up the pipeline stage by stage; bubbles collapse, and a
//  stalled item stays in its stage untouched.
//  rst_n is synchronous, active low, and clears all valid bits.
//
module growing_block_address_translate_top #(
  parameter int NUM_BLOCKS = 64
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // configuration
  input  logic                          cfg_we,
  input  logic [gbat_pkg::CS_W-1:0]     cfg_wdata,
  // input channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [gbat_pkg::ADDR_W-1:0]   in_address,
  // result channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [gbat_pkg::IDX_W-1:0]    out_block_index,
  output logic [gbat_pkg::ADDR_W-1:0]   out_offset_in_block,
  output logic                          out_found
);

  localparam int IW   = $clog2(NUM_BLOCKS);        // table index
  localparam int CW   = IW + 1;                    // sweep counter, reaches NUM_BLOCKS
  localparam int NGRP = (NUM_BLOCKS + gbat_pkg::GRP - 1) / gbat_pkg::GRP;

  // --------------------------------------------------------------------------
  // Cluster size register and block-end table rebuild
  // --------------------------------------------------------------------------
  logic [gbat_pkg::CS_W-1:0]    cs_r;
  logic                         busy_r;
  logic [CW-1:0]                cnt_r;
  logic                         pv_r;       // product in flight
  logic [IW-1:0]                pidx_r;
  logic [gbat_pkg::PROD_W-1:0]  prod_r;
  logic [gbat_pkg::BOUND_W-1:0] bound_r [NUM_BLOCKS];
  logic                         issue;
  logic [gbat_pkg::BOUND_W-1:0] bound_nxt;

  assign issue = busy_r && (cnt_r != CW'(NUM_BLOCKS));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cs_r   <= gbat_pkg::CS_RESET;
      busy_r <= 1'b1;
      cnt_r  <= '0;
      pv_r   <= 1'b0;
    end else if (cfg_we) begin
      // new cluster size: restart the sweep from block 0
      cs_r   <= cfg_wdata;
      busy_r <= 1'b1;
      cnt_r  <= '0;
      pv_r   <= 1'b0;
    end else begin
      pv_r <= issue;
      if (issue) begin
        cnt_r <= cnt_r + CW'(1);
      end
      if (busy_r && !issue && !pv_r) begin
        busy_r <= 1'b0;
      end
    end
  end

  // multiply stage of the sweep
  always_ff @(posedge clk) begin
    pidx_r <= cnt_r[IW-1:0];
    prod_r <= gbat_pkg::cum_units(gbat_pkg::IDX_W'(cnt_r[IW-1:0])) *
              gbat_pkg::PROD_W'(cs_r);
  end

  // ends past the address space clamp to 2^48
  always_comb begin
    if (|prod_r[gbat_pkg::PROD_W-1:gbat_pkg::ADDR_W]) begin
      bound_nxt = {1'b1, {gbat_pkg::ADDR_W{1'b0}}};
    end else begin
      bound_nxt = {1'b0, prod_r[gbat_pkg::ADDR_W-1:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (pv_r) begin
      bound_r[pidx_r] <= bound_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Translation pipeline: S0 input reg, S1 compare, S2 group select, S3 out
  // --------------------------------------------------------------------------
  logic                         rdy0, rdy1, rdy2, rdy3;
  logic                         v0_r, v1_r, v2_r, v3_r;
  logic [gbat_pkg::ADDR_W-1:0]  a0_r, a1_r, a2_r;
  logic [NUM_BLOCKS-1:0]        ge1_r, ge_nxt;
  logic [NUM_BLOCKS:0]          gex;
  logic [NUM_BLOCKS-1:0]        sel;
  logic [gbat_pkg::ADDR_W-1:0]  st_nxt [NGRP];
  logic [gbat_pkg::IDX_W-1:0]   ix_nxt [NGRP];
  logic [gbat_pkg::ADDR_W-1:0]  st2_r  [NGRP];
  logic [gbat_pkg::IDX_W-1:0]   ix2_r  [NGRP];
  logic                         nf2_r;
  logic [gbat_pkg::ADDR_W-1:0]  start3;
  logic [gbat_pkg::IDX_W-1:0]   ix3;
  logic [gbat_pkg::IDX_W-1:0]   out_block_index_r;
  logic [gbat_pkg::ADDR_W-1:0]  out_offset_in_block_r;
  logic                         out_found_r;

  // a stage takes a new item when it is empty or its item moves on
  assign rdy3 = !v3_r || !out_stall;
  assign rdy2 = !v2_r || rdy3;
  assign rdy1 = !v1_r || rdy2;
  assign rdy0 = !v0_r || rdy1;
  assign in_stall = busy_r || !rdy0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (rdy0) v0_r <= in_valid && !busy_r;
      if (rdy1) v1_r <= v0_r;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
    end
  end

  // S1: one comparator per block, "block ends at or below the address"
  always_comb begin
    for (int b = 0; b < NUM_BLOCKS; b++) begin
      ge_nxt[b] = bound_r[b] <= {1'b0, a0_r};
    end
  end

  // S2: thermometer edge picks the last block passed; OR it out in groups
  assign gex = {1'b1, ge1_r};

  always_comb begin
    for (int b = 0; b < NUM_BLOCKS; b++) begin
      sel[b] = gex[b] && !gex[b+1];
    end
    for (int g = 0; g < NGRP; g++) begin
      st_nxt[g] = '0;
      ix_nxt[g] = '0;
    end
    for (int b = 0; b < NUM_BLOCKS; b++) begin
      if (sel[b]) begin
        st_nxt[b / gbat_pkg::GRP] = st_nxt[b / gbat_pkg::GRP] |
                                    bound_r[b][gbat_pkg::ADDR_W-1:0];
        ix_nxt[b / gbat_pkg::GRP] = ix_nxt[b / gbat_pkg::GRP] |
                                    gbat_pkg::IDX_W'(b + 1);
      end
    end
  end

  // S3: final OR, subtract start, zero everything when not found
  always_comb begin
    start3 = '0;
    ix3    = '0;
    for (int g = 0; g < NGRP; g++) begin
      start3 = start3 | st2_r[g];
      ix3    = ix3 | ix2_r[g];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy0) begin
      a0_r <= in_address;
    end
    if (rdy1) begin
      a1_r  <= a0_r;
      ge1_r <= ge_nxt;
    end
    if (rdy2) begin
      a2_r  <= a1_r;
      nf2_r <= ge1_r[NUM_BLOCKS-1];
      for (int g = 0; g < NGRP; g++) begin
        st2_r[g] <= st_nxt[g];
        ix2_r[g] <= ix_nxt[g];
      end
    end
    if (rdy3) begin
      out_found_r           <= !nf2_r;
      out_block_index_r     <= nf2_r ? '0 : ix3;
      out_offset_in_block_r <= nf2_r ? '0 : (a2_r - start3);
    end
  end

  assign out_valid           = v3_r;
  assign out_block_index     = out_block_index_r;
  assign out_offset_in_block = out_offset_in_block_r;
  assign out_found           = out_found_r;

endmodule

@@ design/gbat_chk.sv @@
// ----------------------------------------------------------------------------
// gbat_chk
// Port-level checks for the growing-block address translator.
// ----------------------------------------------------------------------------
module gbat_chk (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        cfg_we,
  input logic                        in_valid,
  input logic                        in_stall,
  input logic                        out_valid,
  input logic                        out_stall,
  input logic [gbat_pkg::IDX_W-1:0]  out_block_index,
  input logic [gbat_pkg::ADDR_W-1:0] out_offset_in_block,
  input logic                        out_found
);

  logic [2:0] inflight_r;
  logic       in_acc;
  logic       out_acc;

  assign in_acc  = in_valid && !in_stall;
  assign out_acc = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inflight_r <= '0;
    end else begin
      inflight_r <= inflight_r + 3'(in_acc) - 3'(out_acc);
    end
  end

  // a miss carries zero index and offset
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_found) |-> (out_block_index == '0 && out_offset_in_block == '0))
    else $error("miss result with nonzero fields");

  // no result without an item accepted earlier
  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (inflight_r != 3'd0))
    else $error("result with no item in flight");

  // a cluster size write starts the table rebuild, input held off
  a_cfg_stall: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we |=> in_stall)
    else $error("input not stalled after cluster size write");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=>
      (out_valid && $stable(out_block_index) && $stable(out_offset_in_block) &&
       $stable(out_found)))
    else $error("stalled result changed");

endmodule

bind growing_block_address_translate_top gbat_chk u_gbat_chk (
  .clk                 (clk),
  .rst_n               (rst_n),
  .cfg_we              (cfg_we),
  .in_valid            (in_valid),
  .in_stall            (in_stall),
  .out_valid           (out_valid),
  .out_stall           (out_stall),
  .out_block_index     (out_block_index),
  .out_offset_in_block (out_offset_in_block),
  .out_found           (out_found)
);

@@ tb/growing_block_address_translate_top_test.sv @@
// ----------------------------------------------------------------------------
// growing_block_address_translate_top_test
// Self-checking bench for the growing-block address translator: a directed
// table, then random phases at several cluster sizes, against an in-bench
// predictor of block index, offset and found.
// ----------------------------------------------------------------------------
module growing_block_address_translate_top_test;

  localparam int NUM_BLOCKS   = 64;
  localparam int PHASES       = 10;
  localparam int PHASE_ITEMS  = 125;   // 10 x 125 random items
  localparam int LONG_HOLD    = 300;   // receiver hold-off in cycles
  localparam int DRAIN_CYC    = 8;     // pipeline is 4 deep
  localparam int LIMIT_CYCLES = 400000;
  localparam logic [gbat_pkg::CS_W-1:0] RESET_CLUSTER = gbat_pkg::CS_W'(4096);
  localparam logic [gbat_pkg::CS_W-1:0] MAX_CLUSTER   = {gbat_pkg::CS_W{1'b1}};

  // One translation as seen on the result channel.
  typedef struct packed {
    logic [gbat_pkg::IDX_W-1:0]  idx;
    logic [gbat_pkg::ADDR_W-1:0] offset;
    logic                        found;
  } xlate_t;

  // Directed table: either a cluster-size write or one address item.
  // Rows with want_known carry a result typed in by hand.
  typedef enum logic {ROW_CFG, ROW_XLATE} row_kind_t;

  typedef struct {
    row_kind_t                   kind;
    logic [gbat_pkg::CS_W-1:0]   cs;
    logic [gbat_pkg::ADDR_W-1:0] addr;
    bit                          want_known;
    xlate_t                      want;
  } row_t;

  logic                          clk;
  logic                          rst_n;
  logic                          cfg_we;
  logic [gbat_pkg::CS_W-1:0]     cfg_wdata;
  logic                          in_valid;
  logic                          in_stall;
  logic [gbat_pkg::ADDR_W-1:0]   in_address;
  logic                          out_valid;
  logic                          out_stall;
  logic [gbat_pkg::IDX_W-1:0]    out_block_index;
  logic [gbat_pkg::ADDR_W-1:0]   out_offset_in_block;
  logic                          out_found;

  // Bench state
  xlate_t                    pending_xlate[$];  // expected results, oldest first
  row_t                      plan[$];
  logic [gbat_pkg::CS_W-1:0] cluster_now;       // predictor's copy of the register
  int              err_count;
  int              cycles;
  int              items_sent;
  int              results_seen;
  int              hits;
  int              misses;
  int              cfg_writes;
  // Idling knobs for sender and receiver
  int              tx_pct;
  int              rx_pct;
  bit              calm;         // last part of the run: no idling at all
  bit              rx_hold_req;  // ask receiver for one long hold-off

  growing_block_address_translate_top #(
    .NUM_BLOCKS(NUM_BLOCKS)
  ) DUT (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_wdata           (cfg_wdata),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_address          (in_address),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_block_index     (out_block_index),
    .out_offset_in_block (out_offset_in_block),
    .out_found           (out_found)
  );

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------

  // Size of block b in clusters: 1,1,2,3,4 then alternately x3/2 and x4/3.
  function automatic logic [63:0] block_units(input int b);
    logic [63:0] u;
    if (b == 0) begin
      return 64'd1;
    end
    if (b < 5) begin
      return 64'(b);
    end
    u = 64'd4;
    for (int k = 4; k < b; k++) begin
      u = (((k - 4) % 2) == 0) ? u / 2 * 3 : u / 3 * 4;
    end
    return u;
  endfunction

  // First byte past block b, in bytes.
  function automatic logic [63:0] block_end(input int b,
                                            input logic [gbat_pkg::CS_W-1:0] cs);
    logic [63:0] sum;
    sum = '0;
    for (int i = 0; i <= b; i++) begin
      sum += block_units(i) * 64'(cs);
    end
    return sum;
  endfunction

  // Walk the blocks until the address falls inside one.
  function automatic xlate_t translate(input logic [gbat_pkg::ADDR_W-1:0] a,
                                       input logic [gbat_pkg::CS_W-1:0] cs);
    xlate_t      r;
    logic [63:0] start;
    logic [63:0] size;
    logic [63:0] a64;
    r     = '0;
    start = '0;
    a64   = 64'(a);
    for (int b = 0; b < NUM_BLOCKS; b++) begin
      size = block_units(b) * 64'(cs);
      if (start + size <= a64) begin
        start += size;
      end else begin
        r.idx    = gbat_pkg::IDX_W'(b);
        r.offset = gbat_pkg::ADDR_W'(a64 - start);
        r.found  = 1'b1;
        return r;
      end
    end
    return r;
  endfunction

  // Random address: mostly near block edges or inside the covered span,
  // some fully random, some just past the last block.
  function automatic logic [gbat_pkg::ADDR_W-1:0] pick_address(
      input logic [gbat_pkg::CS_W-1:0] cs);
    logic [63:0] span;
    logic [63:0] a;
    int          sel;
    span = block_end(NUM_BLOCKS - 1, cs);
    sel  = $urandom_range(0, 99);
    if (sel < 40) begin
      a = block_end($urandom_range(0, NUM_BLOCKS - 1), cs)
          + 64'($urandom_range(0, 6)) - 64'd3;
    end else if (sel < 65) begin
      a = {$urandom, $urandom} % ((span == 0) ? 64'd1 : span);
    end else if (sel < 85) begin
      a = {$urandom, $urandom};
    end else begin
      a = span + 64'($urandom_range(0, 1000));
    end
    return a[gbat_pkg::ADDR_W-1:0];
  endfunction

  function automatic row_t mk_row(input row_kind_t kind,
                                  input logic [gbat_pkg::CS_W-1:0] cs,
                                  input logic [gbat_pkg::ADDR_W-1:0] addr,
                                  input bit known, input int idx,
                                  input logic [gbat_pkg::ADDR_W-1:0] off,
                                  input bit fnd);
    row_t r;
    r.kind        = kind;
    r.cs          = cs;
    r.addr        = addr;
    r.want_known  = known;
    r.want.idx    = gbat_pkg::IDX_W'(idx);
    r.want.offset = off;
    r.want.found  = fnd;
    return r;
  endfunction

  // Append one row to the directed table.
  function automatic void add_row(input row_t r);
    plan = {plan, r};
  endfunction

  // --------------------------------------------------------------------------
  // Clock, cycle limit
  // --------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > LIMIT_CYCLES) begin
        $display("%0t: timeout after %0d cycles, %0d results outstanding",
                 $time, cycles, pending_xlate.size());
        $display("tb: failure");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Receiver: random stall bursts, one long hold on request.
  // rx_left counts the cycles of stall still to serve.
  // --------------------------------------------------------------------------
  initial begin : receiver
    int rx_left;
    rx_left = 0;
    forever begin
      @(negedge clk);
      if (rx_left == 0) begin
        if (rx_hold_req) begin
          rx_left     = LONG_HOLD;
          rx_hold_req = 1'b0;
        end else if (!calm && $urandom_range(0, 99) < rx_pct) begin
          rx_left = $urandom_range(1, 10);
        end
      end
      out_stall <= (rx_left != 0);
      if (rx_left != 0) begin
        rx_left--;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result checker: sampled at the rising edge, item taken when valid and
  // not stalled. Every field against the oldest expectation.
  // --------------------------------------------------------------------------
  initial begin : result_check
    xlate_t want;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) begin
        results_seen++;
        if (pending_xlate.size() == 0) begin
          err_count++;
          $display("%0t: result with none expected: idx %0d off %0d found %0b",
                   $time, out_block_index, out_offset_in_block, out_found);
        end else begin
          want = pending_xlate.pop_front();
          if (out_found) hits++; else misses++;
          if (out_block_index !== want.idx) begin
            err_count++;
            $display("%0t: block_index expected %0d got %0d",
                     $time, want.idx, out_block_index);
          end
          if (out_offset_in_block !== want.offset) begin
            err_count++;
            $display("%0t: offset_in_block expected %0d got %0d",
                     $time, want.offset, out_offset_in_block);
          end
          if (out_found !== want.found) begin
            err_count++;
            $display("%0t: found expected %0b got %0b", $time, want.found, out_found);
          end
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sender tasks
  // --------------------------------------------------------------------------

  // Offer one address, optionally after a random gap, and hold it until
  // taken. The expectation is queued at the accepting edge.
  task automatic drive_item(input logic [gbat_pkg::ADDR_W-1:0] a, input xlate_t want);
    int gap;
    gap = (!calm && $urandom_range(0, 99) < tx_pct) ? $urandom_range(1, 10) : 0;
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid   <= 1'b1;
    in_address <= a;
    do @(posedge clk); while (in_stall);
    pending_xlate = {pending_xlate, want};
    items_sent++;
  endtask

  // Drop valid and wait until every expected result has come back.
  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_xlate.size() != 0) @(negedge clk);
  endtask

  // Cluster-size write, only with the pipeline empty. The block rebuilds its
  // table afterwards and holds in_stall meanwhile; drive_item waits on that.
  task automatic write_cluster(input logic [gbat_pkg::CS_W-1:0] v);
    wait_drained();
    repeat (DRAIN_CYC) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we    <= 1'b0;
    cluster_now = v;
    cfg_writes++;
  endtask

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin : stimulus
    logic [gbat_pkg::CS_W-1:0]   cs;
    logic [gbat_pkg::ADDR_W-1:0] a;
    xlate_t                      want;
    int                          pcts[3];

    rst_n       = 1'b0;
    cfg_we      = 1'b0;
    cfg_wdata   = '0;
    in_valid    = 1'b0;
    in_address  = '0;
    out_stall   = 1'b0;
    cluster_now = RESET_CLUSTER;
    err_count   = 0;
    items_sent  = 0;
    results_seen = 0;
    hits        = 0;
    misses      = 0;
    cfg_writes  = 0;
    tx_pct      = 20;
    rx_pct      = 20;
    calm        = 1'b0;
    rx_hold_req = 1'b0;
    pcts        = '{0, 15, 40};

    // Directed table. At reset the cluster is 4096 bytes.
    add_row(mk_row(ROW_XLATE, '0, 48'd0,        1'b1, 0, 48'd0,    1'b1));
    add_row(mk_row(ROW_XLATE, '0, 48'd4095,     1'b1, 0, 48'd4095, 1'b1));
    add_row(mk_row(ROW_XLATE, '0, 48'd4096,     1'b1, 1, 48'd0,    1'b1));
    add_row(mk_row(ROW_XLATE, '0, 48'd12287,    1'b0, 0, 48'd0,    1'b0));
    // whole table covers far less than the top address
    add_row(mk_row(ROW_XLATE, '0, {gbat_pkg::ADDR_W{1'b1}}, 1'b1, 0, 48'd0, 1'b0));
    // one-byte clusters: block starts 0,1,2,4,7,...
    add_row(mk_row(ROW_CFG, gbat_pkg::CS_W'(1), 48'd0, 1'b0, 0, 48'd0, 1'b0));
    add_row(mk_row(ROW_XLATE, '0, 48'd1,        1'b1, 1, 48'd0,    1'b1));
    add_row(mk_row(ROW_XLATE, '0, 48'd3,        1'b1, 2, 48'd1,    1'b1));
    add_row(mk_row(ROW_XLATE, '0, 48'd7,        1'b1, 4, 48'd0,    1'b1));
    // last byte of block 63, then first byte past the table
    add_row(mk_row(ROW_XLATE, '0, 48'd10737418236, 1'b0, 0, 48'd0, 1'b0));
    add_row(mk_row(ROW_XLATE, '0, 48'd10737418237, 1'b1, 0, 48'd0, 1'b0));
    // zero cluster size: every block is empty, nothing is found
    add_row(mk_row(ROW_CFG,   '0, 48'd0,        1'b0, 0, 48'd0,    1'b0));
    add_row(mk_row(ROW_XLATE, '0, 48'd0,        1'b1, 0, 48'd0,    1'b0));
    add_row(mk_row(ROW_XLATE, '0, {gbat_pkg::ADDR_W{1'b1}}, 1'b1, 0, 48'd0, 1'b0));
    // largest register value: the table spans the whole address range
    add_row(mk_row(ROW_CFG,   MAX_CLUSTER, 48'd0, 1'b0, 0, 48'd0, 1'b0));
    add_row(mk_row(ROW_XLATE, '0, 48'd0,        1'b1, 0, 48'd0,    1'b1));
    add_row(mk_row(ROW_XLATE, '0, 48'd2097150,  1'b1, 0, 48'd2097150, 1'b1));
    add_row(mk_row(ROW_XLATE, '0, {gbat_pkg::ADDR_W{1'b1}}, 1'b0, 0, 48'd0, 1'b0));
    add_row(mk_row(ROW_XLATE, '0, 48'h8000_0000_0000, 1'b0, 0, 48'd0, 1'b0));
    // top of the nominal range, 1 MiB
    add_row(mk_row(ROW_CFG, gbat_pkg::CS_W'(1048576), 48'd0, 1'b0, 0, 48'd0, 1'b0));
    add_row(mk_row(ROW_XLATE, '0, 48'd1048576,  1'b1, 1, 48'd0,    1'b1));
    add_row(mk_row(ROW_XLATE, '0, 48'h5555_5555_5555, 1'b0, 0, 48'd0, 1'b0));
    add_row(mk_row(ROW_XLATE, '0, 48'hAAAA_AAAA_AAAA, 1'b0, 0, 48'd0, 1'b0));

    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_CFG) begin
        write_cluster(plan[i].cs);
      end else begin
        want = plan[i].want_known ? plan[i].want : translate(plan[i].addr, cluster_now);
        drive_item(plan[i].addr, want);
      end
    end

    // Random phases, one cluster size each, extremes first.
    for (int ph = 0; ph < PHASES; ph++) begin
      unique case (ph)
        0: cs = gbat_pkg::CS_W'(1);
        1: cs = MAX_CLUSTER;
        2: cs = '0;
        3: cs = RESET_CLUSTER;
        4: cs = gbat_pkg::CS_W'(1048576);
        default: begin
          cs = $urandom_range(0, 1) ? gbat_pkg::CS_W'($urandom_range(1, 64))
                                    : gbat_pkg::CS_W'($urandom_range(1, MAX_CLUSTER));
        end
      endcase
      write_cluster(cs);

      if (ph == 0) begin
        // back-to-back sender against a long receiver hold: pipeline fills
        // and in_stall has to push back
        tx_pct      = 0;
        rx_pct      = 0;
        rx_hold_req = 1'b1;
      end else begin
        tx_pct = pcts[$urandom_range(0, 2)];
        rx_pct = pcts[$urandom_range(0, 2)];
      end
      calm = (ph == PHASES - 1);

      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // mid-phase, the sender sits out until everything is back
        if (ph == 3 && n == PHASE_ITEMS / 2) begin
          wait_drained();
        end
        a = pick_address(cluster_now);
        drive_item(a, translate(a, cluster_now));
      end
    end

    wait_drained();
    repeat (DRAIN_CYC) @(posedge clk);

    $display("tb: %0d items in, %0d results (%0d found, %0d past the table)",
             items_sent, results_seen, hits, misses);
    $display("tb: %0d cluster-size writes incl. 0, 1, 1 MiB and all-ones", cfg_writes);
    if (err_count == 0 && pending_xlate.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
design/gbat_pkg.sv
design/growing_block_address_translate_top.sv
design/gbat_chk.sv
tb/growing_block_address_translate_top_test.sv
